FILE: src/trk_pkg.sv
package trk_pkg;

  localparam int POS_W       = 15;
  localparam int CNT_W       = 14;
  localparam int LIMIT_W     = 16;
  localparam int MAX_SAMPLES = 16384;
  localparam int POS_CAP_I   = (MAX_SAMPLES < 32767) ? MAX_SAMPLES : 32767;
  localparam logic [POS_W-1:0] POS_CAP     = POS_W'(POS_CAP_I);
  localparam logic [CNT_W-1:0] RUN_CAP     = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] GAP_INIT    = {POS_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(800);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // record kinds
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // event passed from the front to the back
  typedef struct packed {
    logic             has_close;
    logic             fin;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] stop;
  } evt_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/trk_if.sv
interface trk_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [trk_pkg::LIMIT_W-1:0] sample;
  logic                             final_sample;

  modport source (output valid, sample, final_sample, input ready);
  modport sink   (input valid, sample, final_sample, output ready);
endinterface

interface trk_cfg_if;
  logic                             valid;
  logic                             ready;
  logic signed [trk_pkg::LIMIT_W-1:0] level_limit;

  modport source (output valid, level_limit, input ready);
  modport sink   (input valid, level_limit, output ready);
endinterface

interface trk_out_if;
  logic                           valid;
  logic                           ready;
  logic                           record_kind;
  logic [trk_pkg::POS_W-1:0]      run_first;
  logic [trk_pkg::POS_W-1:0]      run_last;
  logic [trk_pkg::POS_W-1:0]      gap_to_previous;
  logic [trk_pkg::CNT_W-1:0]      runs_found;
  logic [trk_pkg::POS_W-1:0]      pair_a_first;
  logic [trk_pkg::POS_W-1:0]      pair_a_last;
  logic [trk_pkg::POS_W-1:0]      pair_b_first;
  logic [trk_pkg::POS_W-1:0]      pair_b_last;
  logic                           pair_valid;
  logic                           last_of_burst;

  modport source (output valid, record_kind, run_first, run_last, gap_to_previous,
                  runs_found, pair_a_first, pair_a_last, pair_b_first, pair_b_last,
                  pair_valid, last_of_burst, input ready);
  modport sink   (input valid, record_kind, run_first, run_last, gap_to_previous,
                  runs_found, pair_a_first, pair_a_last, pair_b_first, pair_b_last,
                  pair_valid, last_of_burst, output ready);
endinterface

FILE: src/trk_fifo.sv
module trk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  trk_pkg::evt_t     push_data,
  input  logic              pop,
  output trk_pkg::evt_t     pop_data,
  output trk_pkg::q_stat_t  stat
);

  trk_pkg::evt_t                mem_r [trk_pkg::Q_DEPTH];
  logic [trk_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [trk_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [trk_pkg::Q_AW:0]       count_r, count_nxt;

  assign stat.full  = (count_r == (trk_pkg::Q_AW+1)'(trk_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/trk_front.sv
module trk_front (
  input  logic              clk,
  input  logic              rst_n,
  trk_in_if.sink            in_ch,
  trk_cfg_if.sink           cfg_ch,
  input  trk_pkg::q_stat_t  q_stat,
  output logic              push,
  output trk_pkg::evt_t     push_data
);

  logic signed [trk_pkg::LIMIT_W-1:0] limit_r;
  logic [trk_pkg::POS_W-1:0]          position_r, position_nxt;
  logic                               inside_r, inside_nxt;
  logic [trk_pkg::POS_W-1:0]          open_start_r, open_start_nxt;

  logic                               accept;
  logic                               below;
  logic [trk_pkg::POS_W-1:0]          pos_inc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;
  assign accept       = in_ch.valid && in_ch.ready;

  assign below   = (in_ch.sample <= limit_r);
  assign pos_inc = (position_r < trk_pkg::POS_CAP) ? position_r + 1'b1 : position_r;

  // classify the sample and update run tracking
  always_comb begin
    push_data.has_close = 1'b0;
    push_data.fin       = in_ch.final_sample;
    push_data.start     = open_start_r;
    push_data.stop      = pos_inc;
    position_nxt        = pos_inc;
    inside_nxt          = 1'b0;
    open_start_nxt      = open_start_r;
    if (below) begin
      if (!inside_r) begin
        push_data.start = pos_inc;
      end
      push_data.has_close = in_ch.final_sample;
      inside_nxt          = 1'b1;
      open_start_nxt      = push_data.start;
    end else if (inside_r) begin
      push_data.has_close = 1'b1;
      push_data.stop      = pos_inc - 1'b1;
    end
    // end of sequence: start over
    if (in_ch.final_sample) begin
      position_nxt   = '0;
      inside_nxt     = 1'b0;
      open_start_nxt = '0;
    end
  end

  // drop items that cause no record
  assign push = accept && (push_data.has_close || push_data.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= trk_pkg::LIMIT_RESET;
      position_r   <= '0;
      inside_r     <= 1'b0;
      open_start_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.level_limit;
      end
      if (accept) begin
        position_r   <= position_nxt;
        inside_r     <= inside_nxt;
        open_start_r <= open_start_nxt;
      end
    end
  end

endmodule

FILE: src/trk_back.sv
module trk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  trk_pkg::q_stat_t  q_stat,
  input  trk_pkg::evt_t     pop_data,
  output logic              pop,
  trk_out_if.source         out_ch
);

  logic [trk_pkg::POS_W-1:0] prior_start_r, prior_start_nxt;
  logic [trk_pkg::POS_W-1:0] prior_end_r, prior_end_nxt;
  logic [trk_pkg::CNT_W-1:0] run_total_r, run_total_nxt;
  logic [trk_pkg::POS_W-1:0] best_gap_r, best_gap_nxt;
  logic [trk_pkg::POS_W-1:0] pa_first_r, pa_first_nxt;
  logic [trk_pkg::POS_W-1:0] pa_last_r, pa_last_nxt;
  logic [trk_pkg::POS_W-1:0] pb_first_r, pb_first_nxt;
  logic [trk_pkg::POS_W-1:0] pb_last_r, pb_last_nxt;
  logic                      pend_sum_r, pend_sum_nxt;

  logic                      valid_r, valid_nxt;
  logic                      kind_r, kind_nxt;
  logic [trk_pkg::POS_W-1:0] first_r, first_nxt;
  logic [trk_pkg::POS_W-1:0] last_r, last_nxt;
  logic [trk_pkg::POS_W-1:0] gap_r, gap_nxt;
  logic [trk_pkg::CNT_W-1:0] found_r, found_nxt;
  logic [trk_pkg::POS_W-1:0] oa_first_r, oa_first_nxt;
  logic [trk_pkg::POS_W-1:0] oa_last_r, oa_last_nxt;
  logic [trk_pkg::POS_W-1:0] ob_first_r, ob_first_nxt;
  logic [trk_pkg::POS_W-1:0] ob_last_r, ob_last_nxt;
  logic                      pvalid_r, pvalid_nxt;
  logic                      lob_r, lob_nxt;

  logic                      slot_free;
  logic                      do_close;
  logic                      do_sum;
  logic [trk_pkg::POS_W-1:0] gap;
  logic                      pair_ok;

  assign slot_free = !valid_r || out_ch.ready;
  assign pop       = slot_free && !pend_sum_r && !q_stat.empty;
  assign do_close  = pop && pop_data.has_close;
  assign do_sum    = slot_free && (pend_sum_r || (pop && !pop_data.has_close));
  assign gap       = (run_total_r != '0) ? pop_data.start - prior_end_r : '0;
  assign pair_ok   = (run_total_r >= trk_pkg::CNT_W'(2));

  // close runs, track the closest pair, build records
  always_comb begin
    prior_start_nxt = prior_start_r;
    prior_end_nxt   = prior_end_r;
    run_total_nxt   = run_total_r;
    best_gap_nxt    = best_gap_r;
    pa_first_nxt    = pa_first_r;
    pa_last_nxt     = pa_last_r;
    pb_first_nxt    = pb_first_r;
    pb_last_nxt     = pb_last_r;
    pend_sum_nxt    = pend_sum_r;

    valid_nxt    = slot_free ? 1'b0 : valid_r;
    kind_nxt     = kind_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    gap_nxt      = gap_r;
    found_nxt    = found_r;
    oa_first_nxt = oa_first_r;
    oa_last_nxt  = oa_last_r;
    ob_first_nxt = ob_first_r;
    ob_last_nxt  = ob_last_r;
    pvalid_nxt   = pvalid_r;
    lob_nxt      = lob_r;

    if (do_close) begin
      if ((run_total_r != '0) && (gap < best_gap_r)) begin
        best_gap_nxt = gap;
        pa_first_nxt = prior_start_r;
        pa_last_nxt  = prior_end_r;
        pb_first_nxt = pop_data.start;
        pb_last_nxt  = pop_data.stop;
      end
      if (run_total_r < trk_pkg::RUN_CAP) begin
        run_total_nxt = run_total_r + 1'b1;
      end
      prior_start_nxt = pop_data.start;
      prior_end_nxt   = pop_data.stop;
      pend_sum_nxt    = pop_data.fin;

      valid_nxt    = 1'b1;
      kind_nxt     = trk_pkg::KIND_RUN;
      first_nxt    = pop_data.start;
      last_nxt     = pop_data.stop;
      gap_nxt      = gap;
      found_nxt    = '0;
      oa_first_nxt = '0;
      oa_last_nxt  = '0;
      ob_first_nxt = '0;
      ob_last_nxt  = '0;
      pvalid_nxt   = 1'b0;
      lob_nxt      = !pop_data.fin;
    end else if (do_sum) begin
      valid_nxt    = 1'b1;
      kind_nxt     = trk_pkg::KIND_SUMMARY;
      first_nxt    = '0;
      last_nxt     = '0;
      gap_nxt      = '0;
      found_nxt    = run_total_r;
      oa_first_nxt = pair_ok ? pa_first_r : '0;
      oa_last_nxt  = pair_ok ? pa_last_r  : '0;
      ob_first_nxt = pair_ok ? pb_first_r : '0;
      ob_last_nxt  = pair_ok ? pb_last_r  : '0;
      pvalid_nxt   = pair_ok;
      lob_nxt      = 1'b1;

      // clear the sequence
      pend_sum_nxt    = 1'b0;
      prior_start_nxt = '0;
      prior_end_nxt   = '0;
      run_total_nxt   = '0;
      best_gap_nxt    = trk_pkg::GAP_INIT;
      pa_first_nxt    = '0;
      pa_last_nxt     = '0;
      pb_first_nxt    = '0;
      pb_last_nxt     = '0;
    end
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      pend_sum_r    <= 1'b0;
      prior_start_r <= '0;
      prior_end_r   <= '0;
      run_total_r   <= '0;
      best_gap_r    <= trk_pkg::GAP_INIT;
      pa_first_r    <= '0;
      pa_last_r     <= '0;
      pb_first_r    <= '0;
      pb_last_r     <= '0;
    end else begin
      valid_r       <= valid_nxt;
      pend_sum_r    <= pend_sum_nxt;
      prior_start_r <= prior_start_nxt;
      prior_end_r   <= prior_end_nxt;
      run_total_r   <= run_total_nxt;
      best_gap_r    <= best_gap_nxt;
      pa_first_r    <= pa_first_nxt;
      pa_last_r     <= pa_last_nxt;
      pb_first_r    <= pb_first_nxt;
      pb_last_r     <= pb_last_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    gap_r      <= gap_nxt;
    found_r    <= found_nxt;
    oa_first_r <= oa_first_nxt;
    oa_last_r  <= oa_last_nxt;
    ob_first_r <= ob_first_nxt;
    ob_last_r  <= ob_last_nxt;
    pvalid_r   <= pvalid_nxt;
    lob_r      <= lob_nxt;
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.record_kind     = kind_r;
  assign out_ch.run_first       = first_r;
  assign out_ch.run_last        = last_r;
  assign out_ch.gap_to_previous = gap_r;
  assign out_ch.runs_found      = found_r;
  assign out_ch.pair_a_first    = oa_first_r;
  assign out_ch.pair_a_last     = oa_last_r;
  assign out_ch.pair_b_first    = ob_first_r;
  assign out_ch.pair_b_last     = ob_last_r;
  assign out_ch.pair_valid      = pvalid_r;
  assign out_ch.last_of_burst   = lob_r;

endmodule

FILE: src/threshold_run_gap_tracker_top.sv
// Run and gap tracker over a stream of signed 16-bit samples.
// in_ch carries one sample per item plus final_sample on the last one of a
// sequence. out_ch carries run records (record_kind 0) as runs close and one
// summary record (record_kind 1) after the final sample; last_of_burst marks
// the last record caused by one input item. cfg_ch writes level_limit and is
// always ready; write it only while the block is idle.
// Path of a record: front classify, 4-entry event queue, back output register.
// Throughput: one input item per cycle while each item causes at most one
// record and out_ch.ready stays high. A final sample that closes a run gives
// two records, which the back end emits one after the other from its single
// output register; the event queue absorbs the difference.
// Reset clears all run state, empties the queue and the output register and
// sets level_limit to 800. When the receiver stalls, the output record holds,
// the queue fills, and in_ch.ready drops once the queue is full.
module threshold_run_gap_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  trk_in_if.sink      in_ch,
  trk_cfg_if.sink     cfg_ch,
  trk_out_if.source   out_ch
);

  trk_pkg::q_stat_t q_stat;
  trk_pkg::evt_t    push_data;
  trk_pkg::evt_t    pop_data;
  logic             push;
  logic             pop;

  trk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  trk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  trk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
